FILE: design/lfle_pkg.sv
// Package for the linked free list engine: field widths, action codes,
// controller state type. No dependencies.
`timescale 1ns / 1ps

package lfle_pkg;

	// Fixed widths of the channel fields
	localparam int unsigned ACTION_W = 2;
	localparam int unsigned BLOCK_W  = 10;
	localparam int unsigned COUNT_W  = 11;

	// Default list capacity
	localparam int unsigned NUM_BLOCKS_DEF = 1024;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH       = 2'd0,
		ACT_POP        = 2'd1,
		ACT_PUSH_RANGE = 2'd2,
		ACT_POP_RANGE  = 2'd3
	} lfle_action_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WALK = 1'b1
	} lfle_state_t;

endpackage

FILE: design/lfle_req_if.sv
// Request channel of the linked free list engine (valid/ready plus action fields).
// Depends on lfle_pkg.
`timescale 1ns / 1ps

interface lfle_req_if;
	import lfle_pkg::*;

	logic               valid;
	logic               ready;
	logic [ACTION_W-1:0] action;
	logic [BLOCK_W-1:0]  block;
	logic [BLOCK_W-1:0]  chain_end;
	logic [COUNT_W-1:0]  count;

	modport source (output valid, action, block, chain_end, count, input ready);
	modport sink   (input valid, action, block, chain_end, count, output ready);
endinterface

FILE: design/lfle_rsp_if.sv
// Response channel of the linked free list engine (valid/ready plus result fields).
// Depends on lfle_pkg.
`timescale 1ns / 1ps

interface lfle_rsp_if;
	import lfle_pkg::*;

	logic               valid;
	logic               ready;
	logic               status;
	logic [BLOCK_W-1:0] first_block;
	logic [BLOCK_W-1:0] last_block;
	logic [COUNT_W-1:0] free_count;
	logic [BLOCK_W-1:0] tail_block;
	logic               tail_valid;

	modport source (output valid, status, first_block, last_block, free_count,
		tail_block, tail_valid, input ready);
	modport sink   (input valid, status, first_block, last_block, free_count,
		tail_block, tail_valid, output ready);
endinterface

FILE: design/lfle_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lfle_ram #(
	parameter int unsigned WIDTH = 10,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: design/linked_free_list_engine_unit.sv
// Linked free list engine: LIFO list of block indices, links kept in a next-index RAM.
// Push, push range and any rejected request give a result in the cycle after transfer;
// pop and pop range walk in ST_WALK, one link RAM read per cycle, one read per block popped.
// Throughput, result taken at once: push or reject every cycle; no request is taken during a walk.
// Reset clears head, size and tail to zero; the link RAM is not cleared (no clearing pass).
// Depends on lfle_pkg, lfle_req_if, lfle_rsp_if, lfle_ram.
`timescale 1ns / 1ps

module linked_free_list_engine_unit #(
	parameter int unsigned NUM_BLOCKS = lfle_pkg::NUM_BLOCKS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	lfle_req_if.sink   req,
	lfle_rsp_if.source rsp
);
	import lfle_pkg::*;

	localparam int unsigned AW = $clog2(NUM_BLOCKS);
	localparam int unsigned SW = $clog2(NUM_BLOCKS + 1);
	localparam int unsigned CW = ((SW > COUNT_W) ? SW : COUNT_W) + 1;

	// Control and list state
	lfle_state_t        state_q, state_d;
	logic [BLOCK_W-1:0] head_q;
	logic [SW-1:0]      size_q;
	logic [BLOCK_W-1:0] tail_q;
	logic [COUNT_W-1:0] rem_q;
	logic [BLOCK_W-1:0] cur_q;
	logic [BLOCK_W-1:0] first_q;

	// Result register
	logic               rsp_valid_q;
	logic               status_q;
	logic [BLOCK_W-1:0] first_block_q;
	logic [BLOCK_W-1:0] last_block_q;
	logic [COUNT_W-1:0] free_count_q;
	logic [BLOCK_W-1:0] tail_block_q;
	logic               tail_valid_q;

	// Link RAM port
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [BLOCK_W-1:0] mem_wdata;
	logic [AW-1:0]      mem_raddr;
	logic [BLOCK_W-1:0] mem_rdata;

	lfle_action_t       act;
	logic               xfer;
	logic               slot_free;
	logic               blk_ok;
	logic               end_ok;
	logic               err;
	logic               is_pop;
	logic               walk_done;
	logic [CW-1:0]      room;
	logic [SW-1:0]      size_push;
	logic [SW-1:0]      size_range;
	logic [SW-1:0]      size_dec;

	lfle_ram #(
		.WIDTH (BLOCK_W),
		.DEPTH (NUM_BLOCKS)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Request checks
	assign act        = lfle_action_t'(req.action);
	assign slot_free  = !rsp_valid_q || rsp.ready;
	assign xfer       = req.valid && req.ready;
	assign blk_ok     = CW'(req.block) < CW'(NUM_BLOCKS);
	assign end_ok     = CW'(req.chain_end) < CW'(NUM_BLOCKS);
	assign room       = CW'(NUM_BLOCKS) - CW'(size_q);
	assign size_push  = size_q + SW'(1);
	assign size_range = SW'(CW'(size_q) + CW'(req.count));
	assign size_dec   = size_q - SW'(1);
	assign walk_done  = (state_q == ST_WALK) && (rem_q == COUNT_W'(1));

	always_comb begin
		err    = 1'b0;
		is_pop = 1'b0;
		unique case (act)
			ACT_PUSH: begin
				err = !blk_ok || (CW'(size_q) >= CW'(NUM_BLOCKS));
			end
			ACT_POP: begin
				err    = (size_q == '0);
				is_pop = 1'b1;
			end
			ACT_PUSH_RANGE: begin
				err = (req.count == '0) || !blk_ok || !end_ok || (CW'(req.count) > room);
			end
			ACT_POP_RANGE: begin
				err    = (req.count == '0) || (CW'(req.count) > CW'(size_q));
				is_pop = 1'b1;
			end
			default: begin
				err = 1'b1;
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (xfer && is_pop && !err) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (rem_q == COUNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State outputs: handshake and link RAM access
	always_comb begin
		req.ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = AW'(req.block);
		mem_wdata = head_q;
		mem_raddr = AW'(head_q);
		unique case (state_q)
			ST_IDLE: begin
				req.ready = slot_free;
				if (xfer && !err && act == ACT_PUSH) begin
					mem_we = 1'b1;
				end else if (xfer && !err && act == ACT_PUSH_RANGE) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(req.chain_end);
				end
			end
			ST_WALK: begin
				// follow the link that just came back
				mem_raddr = AW'(mem_rdata);
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			size_q      <= '0;
			tail_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (xfer && (err || !is_pop)) begin
				rsp_valid_q <= 1'b1;
			end
			if (walk_done) begin
				rsp_valid_q <= 1'b1;
			end
			// list update on pushes
			if (xfer && !err && act == ACT_PUSH) begin
				head_q <= req.block;
				size_q <= size_push;
				if (size_q == '0) begin
					tail_q <= req.block;
				end
			end
			if (xfer && !err && act == ACT_PUSH_RANGE) begin
				head_q <= req.block;
				size_q <= size_range;
				if (size_q == '0) begin
					tail_q <= req.chain_end;
				end
			end
			// walk: one block leaves the list per link read
			if (state_q == ST_WALK) begin
				size_q <= size_dec;
				if (rem_q == COUNT_W'(1)) begin
					head_q <= mem_rdata;
					if (size_dec == '0) begin
						tail_q <= '0;
					end
				end
			end
		end
	end

	// Walk datapath
	always_ff @(posedge clk) begin
		if (xfer && is_pop && !err) begin
			cur_q   <= head_q;
			first_q <= head_q;
			rem_q   <= (act == ACT_POP) ? COUNT_W'(1) : req.count;
		end else if (state_q == ST_WALK) begin
			cur_q <= mem_rdata;
			rem_q <= rem_q - COUNT_W'(1);
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (xfer && err) begin
			status_q      <= 1'b1;
			first_block_q <= '0;
			last_block_q  <= '0;
			free_count_q  <= COUNT_W'(size_q);
			tail_block_q  <= (size_q != '0) ? tail_q : '0;
			tail_valid_q  <= (size_q != '0);
		end else if (xfer && act == ACT_PUSH) begin
			status_q      <= 1'b0;
			first_block_q <= '0;
			last_block_q  <= '0;
			free_count_q  <= COUNT_W'(size_push);
			tail_block_q  <= (size_q == '0) ? req.block : tail_q;
			tail_valid_q  <= 1'b1;
		end else if (xfer && act == ACT_PUSH_RANGE) begin
			status_q      <= 1'b0;
			first_block_q <= '0;
			last_block_q  <= '0;
			free_count_q  <= COUNT_W'(size_range);
			tail_block_q  <= (size_q == '0) ? req.chain_end : tail_q;
			tail_valid_q  <= 1'b1;
		end else if (walk_done) begin
			status_q      <= 1'b0;
			first_block_q <= first_q;
			last_block_q  <= cur_q;
			free_count_q  <= COUNT_W'(size_dec);
			tail_block_q  <= (size_dec != '0) ? tail_q : '0;
			tail_valid_q  <= (size_dec != '0);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.first_block = first_block_q;
	assign rsp.last_block  = last_block_q;
	assign rsp.free_count  = free_count_q;
	assign rsp.tail_block  = tail_block_q;
	assign rsp.tail_valid  = tail_valid_q;

endmodule

FILE: verif/linked_free_list_engine_unit_test.sv
// Testbench for linked_free_list_engine_unit: a directed table followed by random traffic,
// with every result checked in order against its typed row or a predictor of the linked free list.
// Depends on lfle_pkg, lfle_req_if, lfle_rsp_if and the engine RTL.
`timescale 1ns / 1ps

module linked_free_list_engine_unit_test;
	import lfle_pkg::*;

	typedef struct packed {
		lfle_action_t       action;
		logic [BLOCK_W-1:0] block;
		logic [BLOCK_W-1:0] chain_end;
		logic [COUNT_W-1:0] count;
	} request_t;

	typedef struct packed {
		logic               status;
		logic [BLOCK_W-1:0] first_block;
		logic [BLOCK_W-1:0] last_block;
		logic [COUNT_W-1:0] free_count;
		logic [BLOCK_W-1:0] tail_block;
		logic               tail_valid;
	} outcome_t;

	typedef struct packed {
		request_t rq;
		logic     typed;
		outcome_t want;
	} stim_row_t;

	// a run of blocks handed out by a pop, still linked first to last
	typedef struct {
		logic [BLOCK_W-1:0] first;
		logic [BLOCK_W-1:0] last;
		int unsigned        size_n;
	} held_chain_t;

	logic clk;
	logic arst_n;

	lfle_req_if req_ch();
	lfle_rsp_if rsp_ch();

	linked_free_list_engine_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Free list mirror
	logic [BLOCK_W-1:0] list_head;
	logic [BLOCK_W-1:0] list_tail;
	int unsigned        list_len;
	logic [BLOCK_W-1:0] link_mem [NUM_BLOCKS_DEF];
	bit                 link_written [NUM_BLOCKS_DEF];

	outcome_t    expected_q [$];
	held_chain_t held_chains [$];
	int          mismatch_count;
	int          send_idle_pct;
	int          recv_stall_pct;

	int idle_plan  [4] = '{0, 77, 0, 11};
	int stall_plan [4] = '{0, 0, 77, 11};

	// Directed table; typed rows carry the result read straight off the spec
	stim_row_t directed_rows [25] = '{
		'{'{ACT_POP,        10'd0,    10'd0,    11'd0},    1'b1, '{1'b1, 10'd0, 10'd0, 11'd0, 10'd0, 1'b0}},
		'{'{ACT_POP_RANGE,  10'd0,    10'd0,    11'd0},    1'b1, '{1'b1, 10'd0, 10'd0, 11'd0, 10'd0, 1'b0}},
		'{'{ACT_POP_RANGE,  10'd0,    10'd0,    11'd5},    1'b1, '{1'b1, 10'd0, 10'd0, 11'd0, 10'd0, 1'b0}},
		'{'{ACT_PUSH_RANGE, 10'h155,  10'h2AA,  11'd0},    1'b1, '{1'b1, 10'd0, 10'd0, 11'd0, 10'd0, 1'b0}},
		'{'{ACT_PUSH_RANGE, 10'd0,    10'd0,    11'd1025}, 1'b1, '{1'b1, 10'd0, 10'd0, 11'd0, 10'd0, 1'b0}},
		'{'{ACT_PUSH_RANGE, 10'd1023, 10'd1023, 11'd2047}, 1'b1, '{1'b1, 10'd0, 10'd0, 11'd0, 10'd0, 1'b0}},
		'{'{ACT_PUSH,       10'd0,    10'd0,    11'd0},    1'b1, '{1'b0, 10'd0, 10'd0, 11'd1, 10'd0, 1'b1}},
		'{'{ACT_PUSH,       10'd1023, 10'd0,    11'd0},    1'b1, '{1'b0, 10'd0, 10'd0, 11'd2, 10'd0, 1'b1}},
		'{'{ACT_PUSH,       10'h2AA,  10'h155,  11'h555},  1'b1, '{1'b0, 10'd0, 10'd0, 11'd3, 10'd0, 1'b1}},
		'{'{ACT_PUSH,       10'h155,  10'h2AA,  11'h2AA},  1'b1, '{1'b0, 10'd0, 10'd0, 11'd4, 10'd0, 1'b1}},
		'{'{ACT_POP,        10'd0,    10'd0,    11'd0},    1'b1,
			'{1'b0, 10'h155, 10'h155, 11'd3, 10'd0, 1'b1}},
		'{'{ACT_POP_RANGE,  10'd0,    10'd0,    11'd3},    1'b1,
			'{1'b0, 10'h2AA, 10'd0, 11'd0, 10'd0, 1'b0}},
		'{'{ACT_PUSH_RANGE, 10'd1023, 10'd1023, 11'd1},    1'b1,
			'{1'b0, 10'd0, 10'd0, 11'd1, 10'd1023, 1'b1}},
		// head linked to itself, filling the list to capacity
		'{'{ACT_PUSH_RANGE, 10'd1023, 10'd1023, 11'd1023}, 1'b1,
			'{1'b0, 10'd0, 10'd0, 11'd1024, 10'd1023, 1'b1}},
		'{'{ACT_PUSH,       10'd5,    10'd0,    11'd0},    1'b1,
			'{1'b1, 10'd0, 10'd0, 11'd1024, 10'd1023, 1'b1}},
		'{'{ACT_PUSH_RANGE, 10'd7,    10'd7,    11'd1},    1'b1,
			'{1'b1, 10'd0, 10'd0, 11'd1024, 10'd1023, 1'b1}},
		'{'{ACT_POP_RANGE,  10'd0,    10'd0,    11'd1025}, 1'b1,
			'{1'b1, 10'd0, 10'd0, 11'd1024, 10'd1023, 1'b1}},
		'{'{ACT_POP_RANGE,  10'd0,    10'd0,    11'd1024}, 1'b1,
			'{1'b0, 10'd1023, 10'd1023, 11'd0, 10'd0, 1'b0}},
		'{'{ACT_PUSH,       10'd512,  10'd0,    11'd0},    1'b1,
			'{1'b0, 10'd0, 10'd0, 11'd1, 10'd512, 1'b1}},
		'{'{ACT_PUSH,       10'd513,  10'd0,    11'd0},    1'b1,
			'{1'b0, 10'd0, 10'd0, 11'd2, 10'd512, 1'b1}},
		'{'{ACT_POP_RANGE,  10'd0,    10'd0,    11'd2},    1'b1,
			'{1'b0, 10'd513, 10'd512, 11'd0, 10'd0, 1'b0}},
		'{'{ACT_POP_RANGE,  10'd0,    10'd0,    11'd2047}, 1'b1,
			'{1'b1, 10'd0, 10'd0, 11'd0, 10'd0, 1'b0}},
		// give back the run just popped, still linked 513 -> 512
		'{'{ACT_PUSH_RANGE, 10'd513,  10'd512,  11'd2},    1'b1,
			'{1'b0, 10'd0, 10'd0, 11'd2, 10'd512, 1'b1}},
		'{'{ACT_POP,        10'd0,    10'd0,    11'd0},    1'b0, '0},
		'{'{ACT_POP_RANGE,  10'd0,    10'd0,    11'd1},    1'b0, '0}
	};

	// Predicted outcome of one action, advancing the mirrored list
	function automatic outcome_t apply_action(input request_t rq);
		outcome_t           o;
		logic [BLOCK_W-1:0] walk;
		int unsigned        n;
		o = '0;
		n = rq.count;
		case (rq.action)
			ACT_PUSH: begin
				if (list_len >= NUM_BLOCKS_DEF) begin
					o.status = 1'b1;
				end else begin
					link_mem[rq.block]     = list_head;
					link_written[rq.block] = 1'b1;
					if (list_len == 0) list_tail = rq.block;
					list_head = rq.block;
					list_len++;
				end
			end
			ACT_POP: begin
				if (list_len == 0) begin
					o.status = 1'b1;
				end else begin
					o.first_block = list_head;
					o.last_block  = list_head;
					list_head     = link_mem[list_head];
					list_len--;
				end
			end
			ACT_PUSH_RANGE: begin
				if (n == 0 || n > NUM_BLOCKS_DEF - list_len) begin
					o.status = 1'b1;
				end else begin
					link_mem[rq.chain_end]     = list_head;
					link_written[rq.chain_end] = 1'b1;
					if (list_len == 0) list_tail = rq.chain_end;
					list_head = rq.block;
					list_len += n;
				end
			end
			default: begin
				if (n == 0 || n > list_len) begin
					o.status = 1'b1;
				end else begin
					walk = list_head;
					repeat (n - 1) walk = link_mem[walk];
					o.first_block = list_head;
					o.last_block  = walk;
					list_head     = link_mem[walk];
					list_len -= n;
				end
			end
		endcase
		if (list_len == 0) list_tail = '0;
		o.free_count = COUNT_W'(list_len);
		o.tail_block = (list_len != 0) ? list_tail : '0;
		o.tail_valid = (list_len != 0);
		return o;
	endfunction

	// True when pushing first..last as a run of cnt blocks keeps every link the engine
	// may later follow a written one; the link of last is the one the push writes.
	function automatic bit chain_is_linked(input logic [BLOCK_W-1:0] first,
			input logic [BLOCK_W-1:0] last, input int unsigned cnt);
		logic [BLOCK_W-1:0] cur;
		cur = first;
		for (int unsigned p = 1; p < cnt; p++) begin
			if (cur == last) cur = list_head;
			else if (!link_written[cur]) return 1'b0;
			else cur = link_mem[cur];
		end
		return cur == last;
	endfunction

	// Random request, drawn against the current list so that pushed runs are real chains
	function automatic request_t pick_request();
		request_t    rq;
		held_chain_t ch;
		int unsigned room;
		int unsigned cap;
		int unsigned push_pct;
		int unsigned pick;
		rq.action    = ACT_PUSH;
		rq.block     = BLOCK_W'($urandom_range(NUM_BLOCKS_DEF - 1));
		rq.chain_end = BLOCK_W'($urandom_range(NUM_BLOCKS_DEF - 1));
		rq.count     = COUNT_W'(1);
		room = NUM_BLOCKS_DEF - list_len;
		push_pct = (list_len == 0) ? 85 : (list_len < 48) ? 60 : (list_len > 700) ? 25 : 45;
		pick = $urandom_range(99);
		if (pick < 7) begin
			// malformed requests: rejected, list untouched
			case ($urandom_range(3))
				0: begin
					rq.action = ACT_PUSH_RANGE;
					rq.count  = '0;
				end
				1: begin
					rq.action = ACT_PUSH_RANGE;
					rq.count  = COUNT_W'($urandom_range(2047, room + 1));
				end
				2: begin
					rq.action = ACT_POP_RANGE;
					rq.count  = '0;
				end
				default: begin
					rq.action = ACT_POP_RANGE;
					rq.count  = COUNT_W'($urandom_range(2047, list_len + 1));
				end
			endcase
		end else if (pick < 7 + push_pct) begin
			pick = $urandom_range(9);
			if (pick < 3) begin
				rq.action = ACT_PUSH;
				// peel the head off a held run; the rest stays linked
				if (held_chains.size() != 0 && $urandom_range(1) == 1) begin
					ch = held_chains.pop_front();
					rq.block = ch.first;
					if (ch.size_n > 1)
						held_chains.push_back('{link_mem[ch.first], ch.last, ch.size_n - 1});
				end
			end else begin
				rq.action = ACT_PUSH_RANGE;
				if (pick < 7 && held_chains.size() != 0) begin
					ch = held_chains.pop_front();
					rq.block     = ch.first;
					rq.chain_end = ch.last;
					rq.count     = COUNT_W'(ch.size_n);
				end else if (pick < 9 && list_len != 0 && room != 0) begin
					// head linked to itself, repeated
					rq.block     = list_head;
					rq.chain_end = list_head;
					rq.count     = COUNT_W'($urandom_range((room < 16) ? room : 16, 1));
				end else begin
					rq.count = COUNT_W'($urandom_range(8, 1));
				end
				if (rq.count <= room && !chain_is_linked(rq.block, rq.chain_end, rq.count)) begin
					rq.chain_end = rq.block;
					rq.count     = COUNT_W'(1);
				end
			end
		end else begin
			rq.action = ($urandom_range(9) < 4) ? ACT_POP : ACT_POP_RANGE;
			cap = (list_len < 16) ? list_len : 16;
			if (list_len <= 64 && $urandom_range(9) == 0) rq.count = COUNT_W'(list_len);
			else if (cap != 0) rq.count = COUNT_W'($urandom_range(cap, 1));
			else rq.count = COUNT_W'($urandom_range(3));
		end
		return rq;
	endfunction

	// One request transfer; the expectation is queued at the accepting edge
	task automatic issue(input request_t rq, input logic typed, input outcome_t typed_res);
		outcome_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.action    <= rq.action;
		req_ch.block     <= rq.block;
		req_ch.chain_end <= rq.chain_end;
		req_ch.count     <= rq.count;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		predicted = apply_action(rq);
		expected_q.push_back(typed ? typed_res : predicted);
		// popped runs come back later as pushed chains
		if (!predicted.status && (rq.action == ACT_POP || rq.action == ACT_POP_RANGE)) begin
			held_chains.push_back('{predicted.first_block, predicted.last_block,
				(rq.action == ACT_POP) ? 1 : int'(rq.count)});
			if (held_chains.size() > 32) void'(held_chains.pop_front());
		end
	endtask

	task automatic wait_for_results();
		req_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	function automatic void report_mismatch(input string why, input outcome_t want,
			input outcome_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %s: exp st=%0d first=%0d last=%0d free=%0d tail=%0d tv=%0d",
				$realtime, why, want.status, want.first_block, want.last_block,
				want.free_count, want.tail_block, want.tail_valid,
				" | got st=%0d first=%0d last=%0d free=%0d tail=%0d tv=%0d",
				got.status, got.first_block, got.last_block, got.free_count,
				got.tail_block, got.tail_valid);
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result receiver with random stalls
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Result check, in order, field by field
	always @(posedge clk) begin
		outcome_t got;
		outcome_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got = '{rsp_ch.status, rsp_ch.first_block, rsp_ch.last_block,
				rsp_ch.free_count, rsp_ch.tail_block, rsp_ch.tail_valid};
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result", '0, got);
			end else begin
				want = expected_q.pop_front();
				if (got.status !== want.status || got.first_block !== want.first_block ||
						got.last_block !== want.last_block ||
						got.free_count !== want.free_count ||
						got.tail_block !== want.tail_block ||
						got.tail_valid !== want.tail_valid)
					report_mismatch("result mismatch", want, got);
			end
		end
	end

	// Hard stop
	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Stimulus
	initial begin
		mismatch_count   = 0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		list_head        = '0;
		list_tail        = '0;
		list_len         = 0;
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.action    <= ACT_PUSH;
		req_ch.block     <= '0;
		req_ch.chain_end <= '0;
		req_ch.count     <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
		wait_for_results();

		// random traffic, one idling profile per phase, draining in between
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = idle_plan[ph];
			recv_stall_pct = stall_plan[ph];
			repeat (138) issue(pick_request(), 1'b0, '0);
			wait_for_results();
		end

		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: linked_free_list_engine_unit.f
design/lfle_pkg.sv
design/lfle_req_if.sv
design/lfle_rsp_if.sv
design/lfle_ram.sv
design/linked_free_list_engine_unit.sv
verif/linked_free_list_engine_unit_test.sv
